### rtl/scancode_set1_key_decoder_core_assert.svh
// Assertion macros used by the checker file of the scancode decoder.
// No dependencies; include by bare file name.
`ifndef SCANCODE_SET1_KEY_DECODER_CORE_ASSERT_SVH
`define SCANCODE_SET1_KEY_DECODER_CORE_ASSERT_SVH

// Check under clock, disabled while reset is low.
`define SC1KD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check under clock, active during reset as well.
`define SC1KD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/sc1kd_pkg.sv
// Package of the scancode set 1 key decoder: codes, lookup entry types, key tables.
// No dependencies.
`default_nettype none

package sc1kd_pkg;

    localparam logic [7:0] EXT_PREFIX  = 8'hE0;
    localparam int         RELEASE_BIT = 7;
    localparam logic [6:0] LSHIFT_KEY  = 7'h2A;
    localparam logic [6:0] RSHIFT_KEY  = 7'h36;
    localparam logic [6:0] CTRL_KEY    = 7'h1D;
    localparam logic [7:0] ARROW_UP    = 8'h48;
    localparam logic [7:0] ARROW_DOWN  = 8'h50;
    localparam logic [7:0] ARROW_LEFT  = 8'h4B;
    localparam logic [7:0] ARROW_RIGHT = 8'h4D;
    localparam logic [6:0] ESC_KEY     = 7'h01;
    localparam logic [6:0] BSPACE_KEY  = 7'h0E;
    localparam logic [6:0] TAB_KEY     = 7'h0F;
    localparam logic [6:0] ENTER_KEY   = 7'h1C;

    localparam int KEY_W  = 7;
    localparam int CHAR_W = 7;
    localparam int NAME_W = 4;

    typedef enum logic [NAME_W-1:0] {
        NAME_NONE   = 4'd0,
        NAME_ESC    = 4'd1,
        NAME_BSPACE = 4'd2,
        NAME_TAB    = 4'd3,
        NAME_ENTER  = 4'd4,
        NAME_UP     = 4'd5,
        NAME_DOWN   = 4'd6,
        NAME_LEFT   = 4'd7,
        NAME_RIGHT  = 4'd8
    } t_key_name;

    typedef struct packed {
        logic [CHAR_W-1:0] plain_ch;
        logic [CHAR_W-1:0] shift_ch;
        t_key_name         named;
    } t_rom_entry;

    typedef struct packed {
        logic      valid;
        logic      is_ext;
        logic      is_make;
        logic      shift;
        logic      ctrl;
        t_key_name arrow;
    } t_stage_info;

    function automatic logic [CHAR_W-1:0] plain_char(input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] ch;
        case (key)
            7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;
            7'h05: ch = 7'h34;  7'h06: ch = 7'h35;  7'h07: ch = 7'h36;
            7'h08: ch = 7'h37;  7'h09: ch = 7'h38;  7'h0A: ch = 7'h39;
            7'h0B: ch = 7'h30;
            7'h10: ch = 7'h51;  7'h11: ch = 7'h57;  7'h12: ch = 7'h45;
            7'h13: ch = 7'h52;  7'h14: ch = 7'h54;  7'h15: ch = 7'h59;
            7'h16: ch = 7'h55;  7'h17: ch = 7'h49;  7'h18: ch = 7'h4F;
            7'h19: ch = 7'h50;
            7'h1E: ch = 7'h41;  7'h1F: ch = 7'h53;  7'h20: ch = 7'h44;
            7'h21: ch = 7'h46;  7'h22: ch = 7'h47;  7'h23: ch = 7'h48;
            7'h24: ch = 7'h4A;  7'h25: ch = 7'h4B;  7'h26: ch = 7'h4C;
            7'h2C: ch = 7'h5A;  7'h2D: ch = 7'h58;  7'h2E: ch = 7'h43;
            7'h2F: ch = 7'h56;  7'h30: ch = 7'h42;  7'h31: ch = 7'h4E;
            7'h32: ch = 7'h4D;
            7'h39: ch = 7'h20;
            7'h0C: ch = 7'h2D;  7'h0D: ch = 7'h3D;  7'h35: ch = 7'h2F;
            7'h4A: ch = 7'h2D;  7'h4E: ch = 7'h2B;  7'h37: ch = 7'h2A;
            7'h33: ch = 7'h2C;  7'h34: ch = 7'h2E;
            7'h2B: ch = 7'h5C;
            default: ch = '0;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] shift_char(input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] ch;
        case (key)
            7'h07: ch = 7'h5E;
            7'h09: ch = 7'h2A;
            7'h0D: ch = 7'h2B;
            7'h33: ch = 7'h3C;
            7'h34: ch = 7'h3E;
            7'h0C: ch = 7'h5F;
            7'h2B: ch = 7'h7C;
            default: ch = '0;
        endcase
        return ch;
    endfunction

    function automatic t_key_name named_code(input logic [KEY_W-1:0] key);
        t_key_name nm;
        case (key)
            ESC_KEY:    nm = NAME_ESC;
            BSPACE_KEY: nm = NAME_BSPACE;
            TAB_KEY:    nm = NAME_TAB;
            ENTER_KEY:  nm = NAME_ENTER;
            default:    nm = NAME_NONE;
        endcase
        return nm;
    endfunction

    function automatic t_key_name arrow_code(input logic [7:0] code);
        t_key_name nm;
        case (code)
            ARROW_UP:    nm = NAME_UP;
            ARROW_DOWN:  nm = NAME_DOWN;
            ARROW_LEFT:  nm = NAME_LEFT;
            ARROW_RIGHT: nm = NAME_RIGHT;
            default:     nm = NAME_NONE;
        endcase
        return nm;
    endfunction

endpackage

`default_nettype wire

### rtl/sc1kd_key_rom.sv
// Key lookup memory: plain, shifted and named code per key, read data registered.
// Depends on sc1kd_pkg.
`default_nettype none

module sc1kd_key_rom (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [sc1kd_pkg::KEY_W-1:0]  i_addr,
    output sc1kd_pkg::t_rom_entry             o_data
);

    sc1kd_pkg::t_rom_entry r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data.plain_ch <= sc1kd_pkg::plain_char(i_addr);
            r_data.shift_ch <= sc1kd_pkg::shift_char(i_addr);
            r_data.named    <= sc1kd_pkg::named_code(i_addr);
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### rtl/sc1kd_flag_unit.sv
// Modifier and prefix flags, updated per accepted byte; registers the stage info.
// Depends on sc1kd_pkg.
`default_nettype none

module sc1kd_flag_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_code,
    output sc1kd_pkg::t_stage_info o_info
);

    logic                   r_prefix;
    logic                   r_shift;
    logic                   r_ctrl;
    logic                   n_prefix;
    logic                   n_shift;
    logic                   n_ctrl;
    sc1kd_pkg::t_stage_info r_info;
    sc1kd_pkg::t_stage_info n_info;
    logic [sc1kd_pkg::KEY_W-1:0] key;
    logic                   is_release;

    assign key        = i_code[sc1kd_pkg::KEY_W-1:0];
    assign is_release = i_code[sc1kd_pkg::RELEASE_BIT];

    always_comb begin
        n_prefix = r_prefix;
        n_shift  = r_shift;
        n_ctrl   = r_ctrl;
        n_info   = '0;
        if (i_accept) begin
            n_info.valid = 1'b1;
            if (i_code == sc1kd_pkg::EXT_PREFIX) begin
                n_prefix = 1'b1;
            end else begin
                n_prefix = 1'b0;
                if (key == sc1kd_pkg::CTRL_KEY) begin
                    n_ctrl = !is_release;
                end
                if (!r_prefix && (key == sc1kd_pkg::LSHIFT_KEY ||
                                  key == sc1kd_pkg::RSHIFT_KEY)) begin
                    n_shift = !is_release;
                end
                n_info.is_ext  = r_prefix;
                n_info.is_make = !is_release;
                n_info.arrow   = sc1kd_pkg::arrow_code(i_code);
            end
        end
        n_info.shift = n_shift;
        n_info.ctrl  = n_ctrl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= 1'b0;
            r_shift  <= 1'b0;
            r_ctrl   <= 1'b0;
            r_info   <= '0;
        end else if (i_en) begin
            r_prefix <= n_prefix;
            r_shift  <= n_shift;
            r_ctrl   <= n_ctrl;
            r_info   <= n_info;
        end
    end

    assign o_info = r_info;

endmodule

`default_nettype wire

### rtl/scancode_set1_key_decoder_core.sv
// Accepted beats pass the flag and ROM stage, then the output register.
// Throughput: one scancode beat per cycle; the single pipeline advances whenever
// the output register is empty or being taken, so only output backpressure stalls.
// Reset (synchronous, active low) clears the prefix, shift and control flags and
// empties both pipeline stages.
// Depends on sc1kd_pkg, sc1kd_flag_unit, sc1kd_key_rom.
`default_nettype none

module scancode_set1_key_decoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] scan_code
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [6:0] key_char, [10:7] key_name,
                                             // [11] ctrl_down, [15:12] zero
);

    logic                   pipe_en;
    logic                   in_accept;
    sc1kd_pkg::t_stage_info info;
    sc1kd_pkg::t_rom_entry  rom_data;
    logic                   n_valid;
    logic [sc1kd_pkg::CHAR_W-1:0] n_char;
    sc1kd_pkg::t_key_name   n_name;
    logic                   r_valid;
    logic [15:0]            r_data;

    assign pipe_en   = !r_valid || m_axis_tready;
    assign in_accept = s_axis_tvalid && pipe_en;

    sc1kd_flag_unit u_flags (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_accept (in_accept),
        .i_code   (s_axis_tdata),
        .o_info   (info)
    );

    sc1kd_key_rom u_rom (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_addr (s_axis_tdata[sc1kd_pkg::KEY_W-1:0]),
        .o_data (rom_data)
    );

    always_comb begin
        n_valid = 1'b0;
        n_char  = '0;
        n_name  = sc1kd_pkg::NAME_NONE;
        if (info.valid) begin
            if (info.is_ext) begin
                n_name  = info.arrow;
                n_valid = (info.arrow != sc1kd_pkg::NAME_NONE);
            end else if (info.is_make) begin
                if (info.shift && rom_data.shift_ch != '0) begin
                    n_char  = rom_data.shift_ch;
                    n_valid = 1'b1;
                end else if (rom_data.plain_ch != '0) begin
                    n_char  = rom_data.plain_ch;
                    n_valid = 1'b1;
                end else begin
                    n_name  = rom_data.named;
                    n_valid = (rom_data.named != sc1kd_pkg::NAME_NONE);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (pipe_en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_data <= {4'b0000, info.ctrl, n_name, n_char};
        end
    end

    assign s_axis_tready = pipe_en;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;

endmodule

`default_nettype wire

### rtl/sc1kd_checker.sv
// Port-level checker for the scancode decoder, bound to its top level.
// Depends on scancode_set1_key_decoder_core_assert.svh.
`default_nettype none
`include "scancode_set1_key_decoder_core_assert.svh"

module sc1kd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    logic unused_in;

    assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata);

    `SC1KD_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")
    `SC1KD_ASSERT(a_name_range, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[10:7] <= 4'd8, "key name out of range")
    `SC1KD_ASSERT(a_char_xor_name, i_clk, i_rst_n, m_axis_tvalid |-> ((m_axis_tdata[6:0] == 7'd0) != (m_axis_tdata[10:7] == 4'd0)), "beat must carry exactly one of char and name")
    `SC1KD_ASSERT(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[15:12] == 4'd0, "padding bits not zero")
    `SC1KD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind scancode_set1_key_decoder_core sc1kd_checker u_sc1kd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
